### design/mce_pkg.sv
// Package for the memo cache with usage eviction: codes, defaults and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mce_pkg;

  // Default table size.
  localparam int unsigned SLOTS_DEF = 256;

  // Widths of the fixed fields.
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned LIMIT_W = 9;
  localparam int unsigned COUNT_W = 9;

  // Reset value of the entry limit register.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  // Operation codes of the mode field.
  localparam logic [1:0] MODE_PROBE  = 2'd0;
  localparam logic [1:0] MODE_FETCH  = 2'd1;
  localparam logic [1:0] MODE_INSERT = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_OVER     = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;      // latch the item and clear the search results
    logic       scan;       // one step of the key and free slot search
    logic       evict_init; // restart the slot counter for the eviction sweep
    logic       evict;      // one step of the eviction sweep
    logic       insert;     // write the item into its slot
    logic       mark;       // mark the matched slot as fetched
    logic       load_out;   // load the result register
    logic [1:0] status;     // status code for the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] mode;
    logic       batch;
    logic       found;      // key matched during the search
    logic       slot_live;  // matched slot is still valid
    logic       free_found; // a free slot is known
    logic       over;       // entry count above the limit
    logic       scan_done;
    logic       evict_done;
    logic       out_free;   // result register can take a new result
  } stat_t;

endpackage
`default_nettype wire

### design/mce_ctrl.sv
// Controller state machine of the memo cache: sequences search, eviction,
// insert and fetch through commands to the datapath. Uses mce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mce_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire mce_pkg::stat_t st,
  output mce_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_EVICT, S_CHECK, S_INS, S_RDV, S_FIN
  } state_t;

  state_t     state, state_next;
  logic [1:0] code, code_next;

  // Next state and status code.
  always_comb begin
    state_next = state;
    code_next  = code;
    unique case (state)
      S_IDLE: begin
        code_next = mce_pkg::ST_OK;
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (st.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.mode == mce_pkg::MODE_FETCH) begin
          if (st.found) begin
            state_next = S_RDV;
          end else begin
            code_next  = mce_pkg::ST_MISS;
            state_next = S_FIN;
          end
        end else if (st.mode == mce_pkg::MODE_INSERT) begin
          if (st.batch && st.over) state_next = S_EVICT;
          else state_next = S_INS;
        end else begin
          state_next = S_FIN;
        end
      end
      S_EVICT: begin
        if (st.evict_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.over) begin
          code_next  = mce_pkg::ST_OVER;
          state_next = S_FIN;
        end else begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        if (!st.slot_live && !st.free_found) code_next = mce_pkg::ST_FULL;
        state_next = S_FIN;
      end
      S_RDV: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and status register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= mce_pkg::ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  // Commands decoded from the state; the sweep restarts only when one follows.
  always_comb begin
    cmd            = '0;
    cmd.status     = code;
    cmd.start      = (state == S_IDLE) && in_valid;
    cmd.scan       = (state == S_SCAN);
    cmd.evict_init = (state == S_DECIDE) && (state_next == S_EVICT);
    cmd.evict      = (state == S_EVICT);
    cmd.insert     = (state == S_INS);
    cmd.mark       = (state == S_RDV);
    cmd.load_out   = (state == S_FIN) && st.out_free;
  end

  assign in_stall = (state != S_IDLE);

`ifndef SYNTHESIS
  // A fetch never marks a slot unless the search found the key.
  a_mark_found: assert property (@(posedge clk) disable iff (rst)
    cmd.mark |-> st.found) else $error("fetch mark without a match");
  // A finished result leaves only when the result register is free.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && !st.out_free |=> (state == S_FIN))
    else $error("result dropped while the output was busy");
  // Eviction runs only for inserts.
  a_evict_ins: assert property (@(posedge clk) disable iff (rst)
    cmd.evict |-> (st.mode == mce_pkg::MODE_INSERT))
    else $error("eviction outside an insert");
`endif

endmodule
`default_nettype wire

### design/mce_dp.sv
// Datapath of the memo cache: key and value memories, valid and fetched flags,
// entry counter, search registers, limit register and result register. Uses mce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mce_dp #(
  parameter int unsigned SLOTS = mce_pkg::SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mce_pkg::cmd_t                 cmd,
  output mce_pkg::stat_t                     st,
  input  wire logic [1:0]                    mode,
  input  wire logic [mce_pkg::KEY_W-1:0]     key,
  input  wire logic [mce_pkg::VAL_W-1:0]     new_value,
  input  wire logic                          batch_start,
  input  wire logic                          cfg_valid,
  input  wire logic [mce_pkg::LIMIT_W-1:0]   cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               hit,
  output logic [mce_pkg::VAL_W-1:0]          read_value,
  output logic [1:0]                         status,
  output logic [mce_pkg::COUNT_W-1:0]        entry_count
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned XW = (CW > mce_pkg::COUNT_W) ? CW : mce_pkg::COUNT_W;

  logic [mce_pkg::KEY_W-1:0] key_mem [SLOTS];
  logic [mce_pkg::VAL_W-1:0] val_mem [SLOTS];
  logic [SLOTS-1:0]          valid_bits;
  logic [SLOTS-1:0]          fetched;

  logic [CW-1:0]             total;
  logic [CW-1:0]             cnt;
  logic [IW-1:0]             idx;
  logic [IW-1:0]             prev_idx;
  logic [IW-1:0]             match_idx;
  logic [IW-1:0]             free_idx;
  logic                      found;
  logic                      free_found;
  logic                      valid_q;
  logic [mce_pkg::KEY_W-1:0] key_q;
  logic [mce_pkg::VAL_W-1:0] val_q;
  logic [mce_pkg::LIMIT_W-1:0] limit;
  logic [1:0]                mode_r;
  logic                      batch_r;
  logic [mce_pkg::KEY_W-1:0] key_r;
  logic [mce_pkg::VAL_W-1:0] value_r;
  logic [XW-1:0]             total_x;
  logic [XW-1:0]             limit_x;
  logic                      drop;
  logic                      ins_new;

  assign idx      = cnt[IW-1:0];
  assign prev_idx = IW'(cnt - CW'(1));
  assign total_x  = XW'(total);
  assign limit_x  = XW'(limit);
  assign drop     = valid_bits[idx] && !fetched[idx];
  assign ins_new  = cmd.insert && !(found && valid_bits[match_idx]) && free_found;

  // Limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= mce_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r  <= mode;
      batch_r <= batch_start;
      key_r   <= key;
      value_r <= new_value;
    end
  end

  // Key memory: registered read during the search, written on a new entry.
  always_ff @(posedge clk) begin
    if (ins_new) key_mem[free_idx] <= key_r;
    key_q <= key_mem[idx];
  end

  // Value memory: read at the matched slot, written on an insert with a live match or a free slot.
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (found && valid_bits[match_idx]) val_mem[match_idx] <= value_r;
      else if (free_found) val_mem[free_idx] <= value_r;
    end
    val_q <= val_mem[match_idx];
  end

  // Search, eviction sweep, flags and entry counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      total      <= '0;
      cnt        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      if (cmd.start) begin
        cnt        <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end
      // One slot is read per step; its key is compared a step later.
      if (cmd.scan) begin
        if (cnt < CW'(SLOTS)) begin
          valid_q <= valid_bits[idx];
          if (!valid_bits[idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          cnt <= cnt + CW'(1);
        end
        if (cnt != '0 && valid_q && key_q == key_r) begin
          found     <= 1'b1;
          match_idx <= prev_idx;
        end
      end
      if (cmd.evict_init) begin
        cnt        <= '0;
        free_found <= 1'b0;
      end
      // Eviction drops never-fetched entries and finds the lowest free slot.
      if (cmd.evict) begin
        if (drop) begin
          valid_bits[idx] <= 1'b0;
          total           <= total - CW'(1);
        end
        if ((drop || !valid_bits[idx]) && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
        cnt <= cnt + CW'(1);
      end
      if (ins_new) begin
        valid_bits[free_idx] <= 1'b1;
        total                <= total + CW'(1);
      end
    end
  end

  // Fetched flags: set by a fetch hit, cleared by an insert.
  always_ff @(posedge clk) begin
    if (cmd.mark) fetched[match_idx] <= 1'b1;
    if (cmd.insert) begin
      if (found && valid_bits[match_idx]) fetched[match_idx] <= 1'b0;
      else if (free_found) fetched[free_idx] <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit         <= found;
      read_value  <= (mode_r == mce_pkg::MODE_FETCH && found) ? val_q : '0;
      status      <= cmd.status;
      entry_count <= total_x[mce_pkg::COUNT_W-1:0];
    end
  end

  // Status to the controller.
  always_comb begin
    st            = '0;
    st.mode       = mode_r;
    st.batch      = batch_r;
    st.found      = found;
    st.slot_live  = found && valid_bits[match_idx];
    st.free_found = free_found;
    st.over       = total_x > limit_x;
    st.scan_done  = (cnt == CW'(SLOTS));
    st.evict_done = (cnt == CW'(SLOTS - 1));
    st.out_free   = !out_valid || !out_stall;
  end

`ifndef SYNTHESIS
  // The entry counter never exceeds the table size.
  a_total_max: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(SLOTS)) else $error("entry count above table size");
  // A new entry raises the count by one.
  a_total_inc: assert property (@(posedge clk) disable iff (rst)
    ins_new |=> total == $past(total) + CW'(1)) else $error("count not raised");
  // A nonzero read value only comes with a hit and an ok status.
  a_read_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_value != '0 |-> hit && status == mce_pkg::ST_OK)
    else $error("read value without a hit");
`endif

endmodule
`default_nettype wire

### design/memo_cache_usage_eviction_unit.sv
// Top level of the memo cache with usage eviction: joins controller and datapath.
// Depends on mce_pkg, mce_ctrl and mce_dp.
//
// Use: an item (mode, key, new_value, batch_start) transfers on the input
// channel when in_valid is high and in_stall is low. Each item gives exactly
// one result (hit, read_value, status, entry_count), which transfers on the
// output channel when out_valid is high and out_stall is low.
// The entry limit is written through cfg_valid/cfg_data; cfg_ready is always
// high. Write it only while the block is idle.
// Timing: the key search reads one slot of the key memory per cycle; a
// batch-start insert over the limit adds an eviction sweep. One item is in
// work at a time; the next one transfers the cycle after the result is
// loaded, even while that result still waits.
// Reset (rst, synchronous) empties the table at once, sets the limit to 256
// and drops any pending result. A stalled result holds its value; the next
// item's result then waits with in_stall high until the register frees up.
`timescale 1ns / 1ps
`default_nettype none
module memo_cache_usage_eviction_unit #(
  parameter int unsigned SLOTS = mce_pkg::SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  mode,
  input  wire logic [mce_pkg::KEY_W-1:0]   key,
  input  wire logic [mce_pkg::VAL_W-1:0]   new_value,
  input  wire logic                        batch_start,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             hit,
  output logic [mce_pkg::VAL_W-1:0]        read_value,
  output logic [1:0]                       status,
  output logic [mce_pkg::COUNT_W-1:0]      entry_count,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mce_pkg::LIMIT_W-1:0] cfg_data
);

  mce_pkg::cmd_t  cmd;
  mce_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  // Sequencer.
  mce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Storage and search datapath.
  mce_dp #(.SLOTS(SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .mode        (mode),
    .key         (key),
    .new_value   (new_value),
    .batch_start (batch_start),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule
`default_nettype wire
